// ----- rtl/core/iqrp_pkg.sv -----
// ----------------------------------------------------------------------------
// iqrp_pkg
// Shared constants and stage record for the motion report packer.
// ----------------------------------------------------------------------------
package iqrp_pkg;

   localparam int QuatWidth  = 32;
   localparam int AccelWidth = 40;
   localparam int TickWidth  = 16;
   localparam int TempWidth  = 16;
   localparam int WordWidth  = 32;
   localparam int RatioWidth = 31;
   // one quotient bit per stage
   localparam int DivSteps   = 31;

   localparam logic [11:0] TICK_LIMIT   = 12'hfff;
   localparam logic [7:0]  HEADER_TAG   = 8'h0c;
   localparam logic [31:0] RATIO_OFFSET = 32'h4000_0000;
   localparam logic [31:0] RATIO_MAX    = 32'h7fff_ffff;

   typedef struct packed {
      logic                        vld;
      logic                        rej;
      logic [1:0]                  big;
      logic [31:0]                 den;
      logic [2:0][31:0]            rem;
      logic [2:0][RatioWidth-1:0]  quo;
      logic [2:0]                  neg;
      logic [31:0]                 header;
      logic [2:0][31:0]            acc;
      logic [TempWidth-1:0]        temp;
   } stage_type;

endpackage

// ----- rtl/core/imu_quaternion_report_pack.sv -----
// ----------------------------------------------------------------------------
// imu_quaternion_report_pack
// Smallest-three quaternion packer with accel saturation and tick checks.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one motion report per beat (valid/ready), rsp_* carries the
//   packed report (valid/ready). One beat in gives one beat out.
//   From accept to rsp_valid a beat passes an input register, a
//   select stage (magnitudes, largest component, accel codes), 31 restoring
//   divider stages (one quotient bit each, three dividers side by side) and
//   a rounding/pack output register.
//   Throughput is one beat per cycle while rsp_ready is high.
//   When the receiver stalls, the whole pipeline holds and req_ready drops;
//   nothing is dropped or repeated.
//   Reset clears all stage valid bits; the block is ready right after.
//   A report with a tick count above 4095 or an all-zero quaternion comes
//   out with rsp_valid_res low and every other field zero.
// ----------------------------------------------------------------------------
module imu_quaternion_report_pack
   import iqrp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [QuatWidth-1:0]  req_quat_w,
   input  logic [QuatWidth-1:0]  req_quat_x,
   input  logic [QuatWidth-1:0]  req_quat_y,
   input  logic [QuatWidth-1:0]  req_quat_z,
   input  logic [AccelWidth-1:0] req_accel_x,
   input  logic [AccelWidth-1:0] req_accel_y,
   input  logic [AccelWidth-1:0] req_accel_z,
   input  logic [TickWidth-1:0]  req_tick_counter,
   input  logic [TickWidth-1:0]  req_tick_elapsed,
   input  logic [TempWidth-1:0]  req_temperature_code,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_valid_res,
   output logic [WordWidth-1:0]  rsp_header_word,
   output logic [WordWidth-1:0]  rsp_orient_word0,
   output logic [WordWidth-1:0]  rsp_orient_word1,
   output logic [WordWidth-1:0]  rsp_orient_word2,
   output logic [WordWidth-1:0]  rsp_accel_code_x,
   output logic [WordWidth-1:0]  rsp_accel_code_y,
   output logic [WordWidth-1:0]  rsp_accel_code_z,
   output logic [TempWidth-1:0]  rsp_temperature_out
);

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // input register
   logic                       a_vld_ff;
   logic [3:0][QuatWidth-1:0]  a_q_ff;
   logic [2:0][AccelWidth-1:0] a_acc_ff;
   logic [TickWidth-1:0]       a_cnt_ff, a_ela_ff;
   logic [TempWidth-1:0]       a_temp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
      end
      if (adv) begin
         a_q_ff    <= {req_quat_z, req_quat_y, req_quat_x, req_quat_w};
         a_acc_ff  <= {req_accel_z, req_accel_y, req_accel_x};
         a_cnt_ff  <= req_tick_counter;
         a_ela_ff  <= req_tick_elapsed;
         a_temp_ff <= req_temperature_code;
      end
   end

   // select stage
   logic [3:0][31:0] mag;
   logic [3:0]       sgn;
   logic [1:0]       win_a, win_b, big;
   logic [31:0]      mag_a, mag_b;
   logic [1:0]       nidx [3];
   logic             tick_bad;
   stage_type        sel_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sgn[i] = a_q_ff[i][QuatWidth-1];
         mag[i] = sgn[i] ? (32'd0 - a_q_ff[i]) : a_q_ff[i];
      end
      win_a = (mag[1] > mag[0]) ? 2'd1 : 2'd0;
      mag_a = (mag[1] > mag[0]) ? mag[1] : mag[0];
      win_b = (mag[3] > mag[2]) ? 2'd3 : 2'd2;
      mag_b = (mag[3] > mag[2]) ? mag[3] : mag[2];
      big   = (mag_b > mag_a) ? win_b : win_a;
      tick_bad = (a_cnt_ff > {4'd0, TICK_LIMIT}) || (a_ela_ff > {4'd0, TICK_LIMIT});

      sel_in.vld = a_vld_ff;
      sel_in.big = big;
      sel_in.den = mag[big];
      sel_in.rej = tick_bad || (mag[big] == 32'd0);
      for (int i = 0; i < 3; i++) begin
         nidx[i]       = big + 2'(i + 1);
         sel_in.rem[i] = mag[nidx[i]];
         sel_in.quo[i] = '0;
         sel_in.neg[i] = sgn[nidx[i]] ^ sgn[big];
      end
      sel_in.header = {HEADER_TAG, a_ela_ff[11:0], a_cnt_ff[11:0]};
      for (int i = 0; i < 3; i++) begin
         // saturate when bits 39:31 are not a plain sign extension
         if (a_acc_ff[i][39:31] != {9{a_acc_ff[i][39]}}) begin
            sel_in.acc[i] = a_acc_ff[i][39] ? 32'h8000_0000 : 32'h7fff_ffff;
         end else begin
            sel_in.acc[i] = a_acc_ff[i][31:0];
         end
      end
      sel_in.temp = a_temp_ff;
   end

   // divider pipeline: st_ff[0] holds the select result, st_ff[k+1] step k
   stage_type st_ff [DivSteps+1];
   stage_type st_in [DivSteps+1];

   always_comb begin
      logic [32:0] rs;
      logic        qb;
      st_in[0] = sel_in;
      for (int k = 0; k < DivSteps; k++) begin
         st_in[k+1] = st_ff[k];
         for (int i = 0; i < 3; i++) begin
            // first step compares the raw magnitude (quotient bit 30)
            rs = (k == 0) ? {1'b0, st_ff[k].rem[i]} : {st_ff[k].rem[i], 1'b0};
            qb = (rs >= {1'b0, st_ff[k].den});
            st_in[k+1].rem[i] = qb ? 32'(rs - {1'b0, st_ff[k].den}) : rs[31:0];
            st_in[k+1].quo[i] = {st_ff[k].quo[i][RatioWidth-2:0], qb};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= DivSteps; k++) begin
         if (reset) begin
            st_ff[k].vld <= 1'b0;
         end else if (adv) begin
            st_ff[k].vld <= st_in[k].vld;
         end
         if (adv) begin
            st_ff[k].rej    <= st_in[k].rej;
            st_ff[k].big    <= st_in[k].big;
            st_ff[k].den    <= st_in[k].den;
            st_ff[k].rem    <= st_in[k].rem;
            st_ff[k].quo    <= st_in[k].quo;
            st_ff[k].neg    <= st_in[k].neg;
            st_ff[k].header <= st_in[k].header;
            st_ff[k].acc    <= st_in[k].acc;
            st_ff[k].temp   <= st_in[k].temp;
         end
      end
   end

   // round half to even, offset, clamp, pack
   stage_type        fin;
   logic [2:0][30:0] code;
   logic [32:0]      r2;
   logic [30:0]      qr;
   logic [31:0]      cw;
   logic             up;

   always_comb begin
      fin = st_ff[DivSteps];
      for (int i = 0; i < 3; i++) begin
         r2 = {fin.rem[i], 1'b0};
         up = (r2 > {1'b0, fin.den}) || ((r2 == {1'b0, fin.den}) && fin.quo[i][0]);
         qr = fin.quo[i] + {30'd0, up};
         cw = fin.neg[i] ? (RATIO_OFFSET - {1'b0, qr}) : (RATIO_OFFSET + {1'b0, qr});
         code[i] = (cw > RATIO_MAX) ? RATIO_MAX[30:0] : cw[30:0];
      end
   end

   logic                 rsp_valid_ff, res_ff;
   logic [WordWidth-1:0] hdr_ff, w0_ff, w1_ff, w2_ff, ax_ff, ay_ff, az_ff;
   logic [TempWidth-1:0] temp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fin.vld;
      end
      if (adv) begin
         if (fin.rej) begin
            res_ff  <= 1'b0;
            hdr_ff  <= '0;
            w0_ff   <= '0;
            w1_ff   <= '0;
            w2_ff   <= '0;
            ax_ff   <= '0;
            ay_ff   <= '0;
            az_ff   <= '0;
            temp_ff <= '0;
         end else begin
            res_ff  <= 1'b1;
            hdr_ff  <= fin.header;
            w0_ff   <= {code[0][28:0], 1'b0, fin.big};
            w1_ff   <= {code[1][29:0], code[0][30:29]};
            w2_ff   <= {code[2][30:0], code[1][30]};
            ax_ff   <= fin.acc[0];
            ay_ff   <= fin.acc[1];
            az_ff   <= fin.acc[2];
            temp_ff <= fin.temp;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_valid_res       = res_ff;
   assign rsp_header_word     = hdr_ff;
   assign rsp_orient_word0    = w0_ff;
   assign rsp_orient_word1    = w1_ff;
   assign rsp_orient_word2    = w2_ff;
   assign rsp_accel_code_x    = ax_ff;
   assign rsp_accel_code_y    = ay_ff;
   assign rsp_accel_code_z    = az_ff;
   assign rsp_temperature_out = temp_ff;

endmodule

// ----- rtl/core/iqrp_checker.sv -----
// ----------------------------------------------------------------------------
// iqrp_checker
// Port-level checks for the motion report packer, bound to the top level.
// ----------------------------------------------------------------------------
module iqrp_checker
   import iqrp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_valid_res,
   input logic [WordWidth-1:0] rsp_header_word,
   input logic [WordWidth-1:0] rsp_orient_word0
);

   // stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_header_word)
                                  && $stable(rsp_orient_word0))
      else $error("stalled result beat changed");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while output stalled");

   a_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_header_word[31:24] == HEADER_TAG
                                     && rsp_orient_word0[2] == 1'b0)
      else $error("bad header tag or index");

   a_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_header_word == '0 && rsp_orient_word0 == '0)
      else $error("rejected beat not zeroed");

   a_rst: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind imu_quaternion_report_pack iqrp_checker u_iqrp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_valid_res    (rsp_valid_res),
   .rsp_header_word  (rsp_header_word),
   .rsp_orient_word0 (rsp_orient_word0)
);
